// ===== rtl/tdmc_pkg.sv =====
// ----------------------------------------------------------------------------
// tdmc_pkg
// Types and codes shared by the docking mission controller.
// ----------------------------------------------------------------------------
package tdmc_pkg;

  localparam int LIN_W   = 13;
  localparam int ANG_W   = 13;
  localparam int TICK_W  = 6;
  localparam int QUEUE_D = 4;

  // input modes
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_TAG   = 2'd1;
  localparam logic [1:0] MODE_CARGO = 2'd2;
  localparam logic [1:0] MODE_NAV   = 2'd3;

  // result kinds
  localparam logic [2:0] KIND_VEL       = 3'd0;
  localparam logic [2:0] KIND_ATTACH    = 3'd1;
  localparam logic [2:0] KIND_DETACH    = 3'd2;
  localparam logic [2:0] KIND_GO_TARGET = 3'd3;
  localparam logic [2:0] KIND_GO_HOME   = 3'd4;
  localparam logic [2:0] KIND_CANCEL    = 3'd5;
  localparam logic [2:0] KIND_DONE      = 3'd6;

  // mission phases
  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_TO_TARGET = 3'd1;
  localparam logic [2:0] PH_TO_HOME   = 3'd3;
  localparam logic [2:0] PH_DOCKING   = 3'd4;

  localparam logic [1:0] CARGO_NONE = 2'd2;

  // register indexes
  localparam logic [2:0] REG_STOP_DISTANCE = 3'd0;
  localparam logic [2:0] REG_TOLERANCE     = 3'd1;
  localparam logic [2:0] REG_GAIN_DISTANCE = 3'd2;
  localparam logic [2:0] REG_GAIN_HEADING  = 3'd3;
  localparam logic [2:0] REG_MAX_LINEAR    = 3'd4;
  localparam logic [2:0] REG_MIN_LINEAR    = 3'd5;
  localparam logic [2:0] REG_MAX_ANGULAR   = 3'd6;
  localparam logic [2:0] REG_SEARCH_SPEED  = 3'd7;

  // tag closer than 2.5 m starts docking
  localparam logic signed [15:0] TRIGGER_DISTANCE = 16'sd2560;

  typedef struct packed {
    logic [2:0]              kind;
    logic signed [LIN_W-1:0] linear_speed;
    logic signed [ANG_W-1:0] angular_speed;
    logic                    cargo_id;
    logic                    last;
  } res_t;

endpackage

// ===== rtl/tag_docking_mission_controller.sv =====
// ----------------------------------------------------------------------------
// tag_docking_mission_controller
// Mission sequencing, tag tracking and docking velocity control.
// ----------------------------------------------------------------------------
// An item is taken into an input register and worked off from there, when its
// one or two results go into a four-entry output queue; the block takes one
// item per clock as long as the queue holds two results or fewer. Each result
// leaves in a cycle of its own, so items that give two results (attach and go
// target, detach and go home, stop and done) leave as two separate results.
module tag_docking_mission_controller #(
  parameter int TAG_TIMEOUT_TICKS = 40
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // tag_lateral, tag_distance, cargo_code,
                                 // nav_success, nav_canceled, zero fill
  input  logic [1:0]  s_tuser,   // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // linear_speed, angular_speed, cargo_id, zero fill
  output logic [2:0]  m_tuser,   // kind
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  import tdmc_pkg::*;

  localparam int QPTR_W = $clog2(QUEUE_D);
  localparam int QCNT_W = $clog2(QUEUE_D + 1);

  // configuration
  logic [11:0] stop_distance;
  logic [9:0]  tolerance;
  logic [15:0] gain_distance;
  logic [15:0] gain_heading;
  logic [11:0] max_linear;
  logic [11:0] min_linear;
  logic [11:0] max_angular;
  logic [11:0] search_speed;

  // input register
  logic               in_valid;
  logic [1:0]         in_mode;
  logic signed [15:0] in_lateral;
  logic signed [15:0] in_distance;
  logic [1:0]         in_cargo_code;
  logic               in_success;
  logic               in_canceled;

  // mission state
  logic [2:0]         mission_phase, mission_phase_next;
  logic               tag_seen, tag_seen_next;
  logic [TICK_W-1:0]  ticks_since_tag, ticks_since_tag_next;
  logic signed [15:0] stored_lateral, stored_lateral_next;
  logic signed [15:0] stored_distance, stored_distance_next;
  logic [1:0]         active_cargo, active_cargo_next;

  // output queue
  res_t              queue [QUEUE_D];
  logic [QPTR_W-1:0] head, tail;
  logic [QCNT_W-1:0] count;

  logic       process;
  logic       pop;
  logic [1:0] n_res;
  res_t       res0, res1;

  assign cfg_ready = 1'b1;
  assign process   = in_valid && (count <= QCNT_W'(QUEUE_D - 2));
  assign s_tready  = !in_valid || process;
  assign pop       = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_distance <= 12'd154;
      tolerance     <= 10'd20;
      gain_distance <= 16'd1024;
      gain_heading  <= 16'd4096;
      max_linear    <= 12'd205;
      min_linear    <= 12'd51;
      max_angular   <= 12'd410;
      search_speed  <= 12'd307;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_STOP_DISTANCE: stop_distance <= cfg_data[11:0];
        REG_TOLERANCE:     tolerance     <= cfg_data[9:0];
        REG_GAIN_DISTANCE: gain_distance <= cfg_data;
        REG_GAIN_HEADING:  gain_heading  <= cfg_data;
        REG_MAX_LINEAR:    max_linear    <= cfg_data[11:0];
        REG_MIN_LINEAR:    min_linear    <= cfg_data[11:0];
        REG_MAX_ANGULAR:   max_angular   <= cfg_data[11:0];
        REG_SEARCH_SPEED:  search_speed  <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_mode       <= s_tuser;
      in_lateral    <= s_tdata[15:0];
      in_distance   <= s_tdata[31:16];
      in_cargo_code <= s_tdata[33:32];
      in_success    <= s_tdata[34];
      in_canceled   <= s_tdata[35];
    end
  end

  // docking control arithmetic
  logic signed [17:0] err;
  logic [16:0]        abs_err;
  logic [16:0]        abs_lat;
  logic signed [34:0] prod_d;
  logic signed [22:0] lin_raw;
  logic [22:0]        lin_mag;
  logic signed [22:0] lin_cmd;
  logic signed [32:0] prod_h;
  logic signed [33:0] neg_h;
  logic signed [21:0] ang_raw;
  logic signed [21:0] ang_cmd;
  logic signed [ANG_W-1:0] search_ang;

  assign err     = $signed({{2{stored_distance[15]}}, stored_distance})
                 - $signed({6'd0, stop_distance});
  assign abs_err = err[17] ? 17'(-err) : err[16:0];
  assign abs_lat = stored_lateral[15] ? 17'(-$signed({stored_lateral[15], stored_lateral}))
                                      : {1'b0, stored_lateral};
  assign prod_d  = $signed({1'b0, gain_distance}) * err;
  assign lin_raw = prod_d[34:12];
  assign lin_mag = lin_raw[22] ? 23'(-lin_raw) : lin_raw;
  assign prod_h  = $signed({1'b0, gain_heading}) * stored_lateral;
  assign neg_h   = -$signed({prod_h[32], prod_h});
  assign ang_raw = neg_h[33:12];

  always_comb begin
    lin_cmd = '0;
    if (abs_err > {7'd0, tolerance}) begin
      if (lin_raw > $signed({11'd0, max_linear})) begin
        lin_cmd = $signed({11'd0, max_linear});
      end else if (lin_raw < -$signed({11'd0, max_linear})) begin
        lin_cmd = -$signed({11'd0, max_linear});
      end else if (lin_mag < {11'd0, min_linear}) begin
        lin_cmd = (lin_raw > 23'sd0) ? $signed({11'd0, min_linear})
                                     : -$signed({11'd0, min_linear});
      end else begin
        lin_cmd = lin_raw;
      end
    end
    if (ang_raw > $signed({10'd0, max_angular})) begin
      ang_cmd = $signed({10'd0, max_angular});
    end else if (ang_raw < -$signed({10'd0, max_angular})) begin
      ang_cmd = -$signed({10'd0, max_angular});
    end else begin
      ang_cmd = ang_raw;
    end
  end

  assign search_ang = (stored_lateral > 16'sd0) ? -$signed({1'b0, search_speed})
                                                : $signed({1'b0, search_speed});

  // item handling
  always_comb begin
    mission_phase_next   = mission_phase;
    tag_seen_next        = tag_seen;
    ticks_since_tag_next = ticks_since_tag;
    stored_lateral_next  = stored_lateral;
    stored_distance_next = stored_distance;
    active_cargo_next    = active_cargo;
    res0  = '0;
    res1  = '0;
    n_res = 2'd0;
    case (in_mode)
      MODE_TICK: begin
        if (ticks_since_tag >= TICK_W'(TAG_TIMEOUT_TICKS)) begin
          tag_seen_next = 1'b0;
        end else begin
          ticks_since_tag_next = ticks_since_tag + 1'b1;
        end
        if (mission_phase == PH_DOCKING) begin
          if (!tag_seen_next) begin
            res0.kind          = KIND_VEL;
            res0.angular_speed = search_ang;
            n_res              = 2'd1;
          end else if (abs_err < {7'd0, tolerance} && abs_lat < {7'd0, tolerance}) begin
            res0.kind          = KIND_VEL;
            res1.kind          = KIND_DONE;
            n_res              = 2'd2;
            mission_phase_next = PH_IDLE;
            active_cargo_next  = CARGO_NONE;
          end else begin
            res0.kind          = KIND_VEL;
            res0.linear_speed  = lin_cmd[LIN_W-1:0];
            res0.angular_speed = ang_cmd[ANG_W-1:0];
            n_res              = 2'd1;
          end
        end
      end
      MODE_TAG: begin
        stored_lateral_next  = in_lateral;
        stored_distance_next = in_distance;
        tag_seen_next        = 1'b1;
        ticks_since_tag_next = '0;
        if (mission_phase == PH_TO_HOME && in_distance < TRIGGER_DISTANCE) begin
          res0.kind          = KIND_CANCEL;
          n_res              = 2'd1;
          mission_phase_next = PH_DOCKING;
        end
      end
      MODE_CARGO: begin
        if (mission_phase == PH_IDLE) begin
          if (in_cargo_code <= 2'd1) begin
            active_cargo_next  = in_cargo_code;
            res0.kind          = KIND_ATTACH;
            res0.cargo_id      = in_cargo_code[0];
            res1.kind          = KIND_GO_TARGET;
            res1.cargo_id      = in_cargo_code[0];
            n_res              = 2'd2;
            mission_phase_next = PH_TO_TARGET;
          end else begin
            active_cargo_next = CARGO_NONE;
          end
        end
      end
      default: begin
        if (!in_canceled) begin
          if (!in_success) begin
            if (mission_phase != PH_DOCKING) begin
              if (active_cargo <= 2'd1) begin
                res0.kind     = KIND_DETACH;
                res0.cargo_id = active_cargo[0];
                n_res         = 2'd1;
              end
              mission_phase_next = PH_IDLE;
            end
          end else if (mission_phase == PH_TO_TARGET) begin
            if (active_cargo <= 2'd1) begin
              res0.kind     = KIND_DETACH;
              res0.cargo_id = active_cargo[0];
              res1.kind     = KIND_GO_HOME;
              n_res         = 2'd2;
            end else begin
              res0.kind = KIND_GO_HOME;
              n_res     = 2'd1;
            end
            mission_phase_next = PH_TO_HOME;
          end else if (mission_phase == PH_TO_HOME) begin
            res0.kind          = KIND_DONE;
            n_res              = 2'd1;
            mission_phase_next = PH_IDLE;
            active_cargo_next  = CARGO_NONE;
          end
        end
      end
    endcase
    if (n_res == 2'd2) begin
      res1.last = 1'b1;
    end else begin
      res0.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mission_phase   <= PH_IDLE;
      tag_seen        <= 1'b0;
      ticks_since_tag <= '0;
      stored_lateral  <= '0;
      stored_distance <= '0;
      active_cargo    <= CARGO_NONE;
    end else if (process) begin
      mission_phase   <= mission_phase_next;
      tag_seen        <= tag_seen_next;
      ticks_since_tag <= ticks_since_tag_next;
      stored_lateral  <= stored_lateral_next;
      stored_distance <= stored_distance_next;
      active_cargo    <= active_cargo_next;
    end
  end

  // output queue
  logic [1:0] n_push;
  assign n_push = process ? n_res : 2'd0;

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      queue[tail] <= res0;
    end
    if (n_push == 2'd2) begin
      queue[tail + 1'b1] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (pop) begin
        head <= head + 1'b1;
      end
      tail  <= tail + QPTR_W'(n_push);
      count <= count + QCNT_W'(n_push) - QCNT_W'(pop);
    end
  end

  assign m_tvalid = (count != '0);
  assign m_tuser  = queue[head].kind;
  assign m_tlast  = queue[head].last;
  assign m_tdata  = {5'd0, queue[head].cargo_id, queue[head].angular_speed,
                     queue[head].linear_speed};

endmodule

// ===== sim/tag_docking_mission_controller_tb.sv =====
// ----------------------------------------------------------------------------
// tag_docking_mission_controller_tb
// Drives cargo, tag, tick and navigation items through the docking mission
// controller under changing register settings and random back-pressure, and
// checks every command item against a behavioral tracker of the mission.
// ----------------------------------------------------------------------------
module tag_docking_mission_controller_tb;
  import tdmc_pkg::*;

  localparam int TAG_TIMEOUT_TICKS = 40;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;    // tag_lateral, tag_distance, cargo_code,
                                // nav_success, nav_canceled, zero fill
  logic [1:0]  s_tuser = '0;    // mode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;         // linear_speed, angular_speed, cargo_id, zero fill
  logic [2:0]  m_tuser;         // kind
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int hold_left = 0;

  tag_docking_mission_controller #(
    .TAG_TIMEOUT_TICKS(TAG_TIMEOUT_TICKS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  class mission_tracker;
    logic [11:0] stop_distance;
    logic [9:0]  tolerance;
    logic [15:0] gain_distance;
    logic [15:0] gain_heading;
    logic [11:0] max_linear;
    logic [11:0] min_linear;
    logic [11:0] max_angular;
    logic [11:0] search_speed;

    logic [2:0]         phase;
    bit                 tag_seen;
    logic [5:0]         ticks_since_tag;
    logic signed [15:0] tag_lat;
    logic signed [15:0] tag_dist;
    logic [1:0]         cargo;

    res_t new_cmds[$];
    res_t pending_cmds[$];
    int   mismatches;

    function new();
      stop_distance   = 12'd154;
      tolerance       = 10'd20;
      gain_distance   = 16'd1024;
      gain_heading    = 16'd4096;
      max_linear      = 12'd205;
      min_linear      = 12'd51;
      max_angular     = 12'd410;
      search_speed    = 12'd307;
      phase           = PH_IDLE;
      tag_seen        = 1'b0;
      ticks_since_tag = '0;
      tag_lat         = '0;
      tag_dist        = '0;
      cargo           = CARGO_NONE;
      mismatches      = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        REG_STOP_DISTANCE: stop_distance = val[11:0];
        REG_TOLERANCE:     tolerance = val[9:0];
        REG_GAIN_DISTANCE: gain_distance = val;
        REG_GAIN_HEADING:  gain_heading = val;
        REG_MAX_LINEAR:    max_linear = val[11:0];
        REG_MIN_LINEAR:    min_linear = val[11:0];
        REG_MAX_ANGULAR:   max_angular = val[11:0];
        default:           search_speed = val[11:0];
      endcase
    endfunction

    function longint mag(longint v);
      return (v < 0) ? -v : v;
    endfunction

    function void stage(logic [2:0] kind, longint lin, longint ang, logic cargo_id);
      res_t r;
      r.kind          = kind;
      r.linear_speed  = lin[12:0];
      r.angular_speed = ang[12:0];
      r.cargo_id      = cargo_id;
      r.last          = 1'b0;
      new_cmds.push_back(r);
    endfunction

    function void docking_step();
      longint err, lat, lin, ang, tol, tgt, lim, lo;
      tol = longint'(tolerance);
      tgt = longint'(stop_distance);
      lat = longint'(tag_lat);
      err = longint'(tag_dist);
      err = err - tgt;
      lin = 0;
      if (!tag_seen) begin
        // tag lost: spin back toward the side it was last seen on
        ang = longint'(search_speed);
        if (tag_lat > 0) ang = -ang;
        stage(KIND_VEL, 0, ang, 1'b0);
        return;
      end
      if (mag(err) < tol && mag(lat) < tol) begin
        stage(KIND_VEL, 0, 0, 1'b0);
        stage(KIND_DONE, 0, 0, 1'b0);
        phase = PH_IDLE;
        cargo = CARGO_NONE;
        return;
      end
      if (mag(err) > tol) begin
        lim = longint'(max_linear);
        lo  = longint'(min_linear);
        lin = (longint'(gain_distance) * err) >>> 12;
        if (lin > lim) lin = lim;
        else if (lin < -lim) lin = -lim;
        else if (mag(lin) < lo) lin = (lin > 0) ? lo : -lo;
      end
      lim = longint'(max_angular);
      ang = (-(longint'(gain_heading) * lat)) >>> 12;
      if (ang > lim) ang = lim;
      else if (ang < -lim) ang = -lim;
      stage(KIND_VEL, lin, ang, 1'b0);
    endfunction

    function void take_item(logic [1:0] mode, logic [39:0] data);
      logic [1:0] code;
      logic       ok;
      logic       canc;
      res_t       r;
      code = data[33:32];
      ok   = data[34];
      canc = data[35];
      new_cmds.delete();
      case (mode)
        MODE_TICK: begin
          if (ticks_since_tag >= 6'(TAG_TIMEOUT_TICKS)) tag_seen = 1'b0;
          else ticks_since_tag = ticks_since_tag + 6'd1;
          if (phase == PH_DOCKING) docking_step();
        end
        MODE_TAG: begin
          tag_lat         = data[15:0];
          tag_dist        = data[31:16];
          tag_seen        = 1'b1;
          ticks_since_tag = '0;
          if (phase == PH_TO_HOME && tag_dist < TRIGGER_DISTANCE) begin
            stage(KIND_CANCEL, 0, 0, 1'b0);
            phase = PH_DOCKING;
          end
        end
        MODE_CARGO: begin
          if (phase == PH_IDLE) begin
            if (code <= 2'd1) begin
              cargo = code;
              stage(KIND_ATTACH, 0, 0, code[0]);
              stage(KIND_GO_TARGET, 0, 0, code[0]);
              phase = PH_TO_TARGET;
            end else begin
              cargo = CARGO_NONE;
            end
          end
        end
        default: begin
          if (!canc) begin
            if (!ok) begin
              if (phase != PH_DOCKING) begin
                if (cargo <= 2'd1) stage(KIND_DETACH, 0, 0, cargo[0]);
                phase = PH_IDLE;
              end
            end else if (phase == PH_TO_TARGET) begin
              if (cargo <= 2'd1) stage(KIND_DETACH, 0, 0, cargo[0]);
              stage(KIND_GO_HOME, 0, 0, 1'b0);
              phase = PH_TO_HOME;
            end else if (phase == PH_TO_HOME) begin
              stage(KIND_DONE, 0, 0, 1'b0);
              phase = PH_IDLE;
              cargo = CARGO_NONE;
            end
          end
        end
      endcase
      while (new_cmds.size() > 0) begin
        r = new_cmds.pop_front();
        r.last = (new_cmds.size() == 0);
        pending_cmds.push_back(r);
      end
    endfunction

    function void match_result(logic [2:0] kind, logic [12:0] lin, logic [12:0] ang,
                               logic cargo_id, logic last);
      res_t want;
      if (pending_cmds.size() == 0) begin
        $error("unexpected item: kind %0d", kind);
        mismatches++;
        return;
      end
      want = pending_cmds.pop_front();
      if (kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, kind);
        mismatches++;
      end
      if (lin !== want.linear_speed) begin
        $error("linear_speed: expected %0d, got %0d",
               $signed(want.linear_speed), $signed(lin));
        mismatches++;
      end
      if (ang !== want.angular_speed) begin
        $error("angular_speed: expected %0d, got %0d",
               $signed(want.angular_speed), $signed(ang));
        mismatches++;
      end
      if (cargo_id !== want.cargo_id) begin
        $error("cargo_id: expected %0d, got %0d", want.cargo_id, cargo_id);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, last);
        mismatches++;
      end
    endfunction
  endclass

  mission_tracker tracker;

  always #2 clk = ~clk;

  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_tready = 1'b0;
      hold_left = hold_left - 1;
    end else begin
      m_tready = ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      tracker.match_result(m_tuser, m_tdata[12:0], m_tdata[25:13], m_tdata[26], m_tlast);
  end

  function automatic logic [39:0] pack_in(logic [15:0] lat, logic [15:0] fwd,
                                          logic [1:0] code, logic ok, logic canc);
    return {4'b0, canc, ok, code, fwd, lat};
  endfunction

  function automatic int jitter(int s);
    return int'($urandom_range(0, 2 * s)) - s;
  endfunction

  task automatic push_item(logic [1:0] mode, logic [39:0] data);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = mode;
    s_tdata  = data;
    do @(posedge clk); while (!s_tready);
    tracker.take_item(mode, data);
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic send_tick();
    push_item(MODE_TICK, '0);
  endtask

  task automatic send_pose(int lat, int fwd);
    push_item(MODE_TAG, pack_in(lat[15:0], fwd[15:0], 2'd0, 1'b0, 1'b0));
  endtask

  task automatic send_cargo(logic [1:0] code);
    push_item(MODE_CARGO, pack_in('0, '0, code, 1'b0, 1'b0));
  endtask

  task automatic send_nav(logic ok, logic canc);
    push_item(MODE_NAV, pack_in('0, '0, 2'd0, ok, canc));
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic load_regs(int td, int tol, int gd, int gh, int mxl, int mnl, int mxa, int ss);
    write_reg(REG_STOP_DISTANCE, td[15:0]);
    write_reg(REG_TOLERANCE, tol[15:0]);
    write_reg(REG_GAIN_DISTANCE, gd[15:0]);
    write_reg(REG_GAIN_HEADING, gh[15:0]);
    write_reg(REG_MAX_LINEAR, mxl[15:0]);
    write_reg(REG_MIN_LINEAR, mnl[15:0]);
    write_reg(REG_MAX_ANGULAR, mxa[15:0]);
    write_reg(REG_SEARCH_SPEED, ss[15:0]);
  endtask

  task automatic load_random_regs();
    load_regs($urandom_range(0, 1500), $urandom_range(1, 300), $urandom_range(0, 65535),
              $urandom_range(0, 65535), $urandom_range(0, 4095), $urandom_range(0, 600),
              $urandom_range(0, 4095), $urandom_range(0, 4095));
  endtask

  // wait for every command item, then let items with no result clear the pipe
  task automatic settle();
    while (tracker.pending_cmds.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  // a docking left over from the last setting is brought home, if the tolerance is above zero
  task automatic finish_docking();
    if (tracker.phase == PH_DOCKING && tracker.tolerance > 0) begin
      send_pose(0, int'(tracker.stop_distance));
      send_tick();
    end
  endtask

  task automatic mission_step();
    int pick, tol, tgt, lat, fwd;
    pick = $urandom_range(0, 99);
    tol  = int'(tracker.tolerance);
    tgt  = int'(tracker.stop_distance);
    if (pick < 12) begin
      // noise
      push_item(2'($urandom_range(0, 3)), {4'b0, 4'($urandom), 32'($urandom)});
      return;
    end
    case (tracker.phase)
      PH_IDLE: begin
        if (pick < 80) send_cargo(2'($urandom_range(0, 1)));
        else if (pick < 88) send_cargo(2'd2);
        else if (pick < 94) send_tick();
        else send_nav(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
      PH_TO_TARGET: begin
        if (pick < 75) send_nav(1'b1, 1'b0);
        else if (pick < 83) send_nav(1'b0, 1'b0);
        else if (pick < 90) send_nav(1'($urandom_range(0, 1)), 1'b1);
        else if (pick < 95) send_tick();
        else send_pose(jitter(3000), jitter(6000));
      end
      PH_TO_HOME: begin
        if (pick < 70) send_pose(jitter(2000), int'($urandom_range(0, 5400)) - 400);
        else if (pick < 78) send_nav(1'b1, 1'b0);
        else if (pick < 83) send_nav(1'b0, 1'b0);
        else send_tick();
      end
      default: begin
        if (pick < 16) begin
          repeat (TAG_TIMEOUT_TICKS + 2) send_tick();
        end else if (pick < 55) begin
          send_tick();
        end else if (pick < 60) begin
          send_nav(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else begin
          if ($urandom_range(0, 3) == 0 && tol > 0) begin
            fwd = tgt + jitter(tol - 1);
            lat = jitter(tol - 1);
          end else begin
            fwd = tgt + jitter(600);
            lat = jitter(400);
          end
          send_pose(lat, fwd);
        end
      end
    endcase
  endtask

  task automatic run_missions(int n, int src_pct, int sink_pct);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    repeat (n) mission_step();
  endtask

  initial begin
    tracker = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part, reset register values
    send_tick();
    send_cargo(2'd2);
    send_nav(1'b0, 1'b0);
    send_cargo(2'd0);
    send_cargo(2'd1);
    send_nav(1'b1, 1'b1);
    send_nav(1'b0, 1'b0);
    send_cargo(2'd1);
    send_nav(1'b1, 1'b0);
    send_pose(100, 2560);
    send_pose(32767, 2559);
    send_tick();
    send_pose(-32768, -32768);
    send_tick();
    send_pose(0, 32767);
    send_tick();
    send_pose(5, 154 + 20);
    send_tick();
    send_pose(-7, 154 + 30);
    send_tick();
    repeat (TAG_TIMEOUT_TICKS + 2) send_tick();
    send_nav(1'b0, 1'b0);
    send_pose(0, 154);
    send_tick();
    send_cargo(2'd0);
    send_nav(1'b1, 1'b0);
    send_nav(1'b1, 1'b0);

    run_missions(70, 0, 0);

    settle();
    load_random_regs();
    finish_docking();
    run_missions(75, 80, 0);

    settle();
    load_regs(4095, 1023, 65535, 65535, 4095, 4095, 4095, 4095);
    finish_docking();
    run_missions(75, 0, 80);

    settle();
    load_regs(0, 0, 0, 0, 0, 0, 0, 0);
    run_missions(50, 20, 20);

    settle();
    load_random_regs();
    finish_docking();
    hold_left = 300;
    run_missions(75, 0, 0);

    settle();
    load_regs(300, 5, 40000, 9000, 60, 500, 100, 4095);
    finish_docking();
    run_missions(45, 20, 20);
    settle();
    run_missions(45, 0, 20);

    while (tracker.pending_cmds.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending_cmds.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
